### src/beam_power_accumulator_unit_macros.svh
// Assertion macros shared by the accumulator RTL.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef BEAM_POWER_ACCUMULATOR_UNIT_MACROS_SVH
`define BEAM_POWER_ACCUMULATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BPA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/bpa_pkg.sv
`timescale 1ns / 1ps

package bpa_pkg;

	// Default channel count of the accumulator store.
	localparam int NUM_CHANNELS_DEF = 1024;

	// Datapath widths.
	localparam int SAMPLE_W = 16;
	localparam int CHAN_W   = 10;
	localparam int DIR_W    = 8;
	localparam int PROD_W   = 32;
	localparam int PSUM_W   = 33;
	localparam int TERM_W   = 18;
	localparam int ACC_W    = 27;
	localparam int SQ_W     = 53;
	localparam int POWER_W  = 54;

	// Right shift of the rounding step, in bits.
	localparam int RND_SHIFT = 15;

	// One input beat: antenna sample, steering weight and tags.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] data_real;
		logic signed [SAMPLE_W-1:0] data_imag;
		logic signed [SAMPLE_W-1:0] weight_real;
		logic signed [SAMPLE_W-1:0] weight_imag;
		logic [CHAN_W-1:0]          channel;
		logic [DIR_W-1:0]           direction;
		logic                       last_antenna;
	} bpa_sample_t;

	// One output beat: beam power and its tags.
	typedef struct packed {
		logic [POWER_W-1:0] beam_power;
		logic [CHAN_W-1:0]  out_channel;
		logic [DIR_W-1:0]   out_direction;
	} bpa_result_t;

	// One complex accumulator entry.
	typedef struct packed {
		logic signed [ACC_W-1:0] re;
		logic signed [ACC_W-1:0] im;
	} bpa_acc_t;

endpackage

### src/beam_power_accumulator_unit.sv
`timescale 1ns / 1ps
// Beam power accumulator.
// Unless stalled, samp takes one beat per cycle: an antenna sample for one frequency
// channel and that antenna's Q1.15 steering weight. The complex product, rounded by
// 15 bits, is added with saturation into a 27-bit complex accumulator for the channel.
// A beat flagged last_antenna also makes one beat on the pwr channel: the squared
// magnitude of the new sum with its channel and direction, and the entry is cleared.
// Beats whose channel is NUM_CHANNELS or above are dropped without effect.
// Throughput is one beat per cycle while not halted, set by the five-stage pipeline:
// multiply, round, accumulate with forwarding around the store's registered read,
// square, add. An accepted last beat goes from stage 5 into the output register.
// After reset a clearing pass zeroes the store, one entry per cycle; samp_stall is
// high for the whole pass.
// When pwr_stall holds a waiting result, one more result goes to a skid register;
// with the skid full the pipeline halts and samp_stall rises until pwr drains.
`include "beam_power_accumulator_unit_macros.svh"

module beam_power_accumulator_unit #(
	parameter int NUM_CHANNELS = bpa_pkg::NUM_CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  samp_valid,
	output logic                  samp_stall,
	input  bpa_pkg::bpa_sample_t  samp,
	output logic                  pwr_valid,
	input  logic                  pwr_stall,
	output bpa_pkg::bpa_result_t  pwr
);

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_CHANNELS - 1);
	localparam int PW = bpa_pkg::PROD_W;
	localparam int SW = bpa_pkg::PSUM_W;
	localparam int TW = bpa_pkg::TERM_W;
	localparam int CW = bpa_pkg::ACC_W;
	localparam logic signed [CW-1:0] ACC_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] ACC_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [SW-1:0] RND_BIAS = SW'(1) <<< (bpa_pkg::RND_SHIFT - 1);

	// Accumulator store.
	bpa_pkg::bpa_acc_t mem [NUM_CHANNELS];

	logic clr_active_q;
	logic [AW-1:0] clr_addr_q;
	logic skid_valid_q;
	logic out_valid_q;
	bpa_pkg::bpa_result_t out_q;
	bpa_pkg::bpa_result_t skid_q;

	logic en;
	logic accept;
	logic in_range;

	// Stage valid bits.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// Stage 1: registered input.
	bpa_pkg::bpa_sample_t samp_s1;
	logic [AW-1:0] addr_s1;

	// Stage 2: partial products and stored entry.
	logic signed [PW-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	bpa_pkg::bpa_acc_t rd_s2;
	logic [AW-1:0] addr_s2;
	logic [bpa_pkg::CHAN_W-1:0] ch_s2;
	logic [bpa_pkg::DIR_W-1:0] dir_s2;
	logic last_s2;

	// Stage 3: rounded term and up-to-date accumulator.
	logic signed [TW-1:0] term_re_s3, term_im_s3;
	bpa_pkg::bpa_acc_t acc_s3;
	logic [AW-1:0] addr_s3;
	logic [bpa_pkg::CHAN_W-1:0] ch_s3;
	logic [bpa_pkg::DIR_W-1:0] dir_s3;
	logic last_s3;

	// Stage 4: new sum and the value written back.
	bpa_pkg::bpa_acc_t sum_s4;
	bpa_pkg::bpa_acc_t wd_s4;
	logic [AW-1:0] addr_s4;
	logic [bpa_pkg::CHAN_W-1:0] ch_s4;
	logic [bpa_pkg::DIR_W-1:0] dir_s4;
	logic last_s4;

	// Stage 5: squares.
	logic [bpa_pkg::SQ_W-1:0] sq_re_s5, sq_im_s5;
	logic [bpa_pkg::CHAN_W-1:0] ch_s5;
	logic [bpa_pkg::DIR_W-1:0] dir_s5;
	logic last_s5;

	logic signed [SW-1:0] psum_re, psum_im;
	logic signed [SW-1:0] pbias_re, pbias_im;
	logic signed [CW:0] raw_re, raw_im;
	bpa_pkg::bpa_acc_t new_sum;
	bpa_pkg::bpa_acc_t wdata;
	bpa_pkg::bpa_acc_t fwd;
	logic wen;
	logic signed [2*CW-1:0] sq_re_w, sq_im_w;
	logic rv;
	bpa_pkg::bpa_result_t r;

	// Handshake and pipeline enable; the pipeline halts only while the skid is full.
	assign en         = !skid_valid_q;
	assign samp_stall = clr_active_q || skid_valid_q;
	assign accept     = samp_valid && !samp_stall;
	assign in_range   = ({{(32-bpa_pkg::CHAN_W){1'b0}}, samp.channel} < 32'(NUM_CHANNELS));

	// Clearing pass over the store after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			if (clr_addr_q == LAST_ADDR) begin
				clr_active_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept && in_range;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Rounding of the complex product and saturating accumulate.
	always_comb begin
		psum_re  = SW'(p_rr_s2) - SW'(p_ii_s2);
		psum_im  = SW'(p_ri_s2) + SW'(p_ir_s2);
		pbias_re = psum_re + RND_BIAS;
		pbias_im = psum_im + RND_BIAS;

		raw_re = (CW+1)'(acc_s3.re) + (CW+1)'(term_re_s3);
		raw_im = (CW+1)'(acc_s3.im) + (CW+1)'(term_im_s3);
		if (raw_re[CW] != raw_re[CW-1]) begin
			new_sum.re = raw_re[CW] ? ACC_MIN : ACC_MAX;
		end else begin
			new_sum.re = raw_re[CW-1:0];
		end
		if (raw_im[CW] != raw_im[CW-1]) begin
			new_sum.im = raw_im[CW] ? ACC_MIN : ACC_MAX;
		end else begin
			new_sum.im = raw_im[CW-1:0];
		end

		// A last antenna leaves the entry cleared.
		wdata = last_s3 ? '0 : new_sum;
		wen   = en && v_s3;

		// The registered read misses the writes of the two stages ahead of it.
		if (v_s3 && (addr_s3 == addr_s2)) begin
			fwd = wdata;
		end else if (v_s4 && (addr_s4 == addr_s2)) begin
			fwd = wd_s4;
		end else begin
			fwd = rd_s2;
		end

		sq_re_w = sum_s4.re * sum_s4.re;
		sq_im_w = sum_s4.im * sum_s4.im;

		rv = v_s5 && last_s5;
		r.beam_power    = bpa_pkg::POWER_W'(sq_re_s5) + bpa_pkg::POWER_W'(sq_im_s5);
		r.out_channel   = ch_s5;
		r.out_direction = dir_s5;
	end

	// Store port: clearing writes, write-back from stage 3, registered read.
	always_ff @(posedge clk) begin
		if (clr_active_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wen) begin
			mem[addr_s3] <= wdata;
		end
		if (en) begin
			rd_s2 <= mem[addr_s1];
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (en) begin
			samp_s1 <= samp;
			addr_s1 <= AW'(samp.channel);

			p_rr_s2 <= samp_s1.data_real * samp_s1.weight_real;
			p_ii_s2 <= samp_s1.data_imag * samp_s1.weight_imag;
			p_ri_s2 <= samp_s1.data_real * samp_s1.weight_imag;
			p_ir_s2 <= samp_s1.data_imag * samp_s1.weight_real;
			addr_s2 <= addr_s1;
			ch_s2   <= samp_s1.channel;
			dir_s2  <= samp_s1.direction;
			last_s2 <= samp_s1.last_antenna;

			term_re_s3 <= pbias_re[SW-1:bpa_pkg::RND_SHIFT];
			term_im_s3 <= pbias_im[SW-1:bpa_pkg::RND_SHIFT];
			acc_s3     <= fwd;
			addr_s3    <= addr_s2;
			ch_s3      <= ch_s2;
			dir_s3     <= dir_s2;
			last_s3    <= last_s2;

			sum_s4  <= new_sum;
			wd_s4   <= wdata;
			addr_s4 <= addr_s3;
			ch_s4   <= ch_s3;
			dir_s4  <= dir_s3;
			last_s4 <= last_s3;

			sq_re_s5 <= sq_re_w[bpa_pkg::SQ_W-1:0];
			sq_im_s5 <= sq_im_w[bpa_pkg::SQ_W-1:0];
			ch_s5    <= ch_s4;
			dir_s5   <= dir_s4;
			last_s5  <= last_s4;
		end
	end

	// Output register and skid control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (en) begin
			if (rv) begin
				if (out_valid_q && pwr_stall) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (!pwr_stall) begin
				out_valid_q <= 1'b0;
			end
		end else if (!pwr_stall) begin
			skid_valid_q <= 1'b0;
		end
	end

	// Output and skid payload.
	always_ff @(posedge clk) begin
		if (en) begin
			if (rv) begin
				if (out_valid_q && pwr_stall) begin
					skid_q <= r;
				end else begin
					out_q <= r;
				end
			end
		end else if (!pwr_stall) begin
			out_q <= skid_q;
		end
	end

	assign pwr_valid = out_valid_q;
	assign pwr       = out_q;

	// The skid holds a beat only behind a waiting output beat.
	`BPA_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with output empty")
	// The skid fills only when the output beat was stalled.
	`BPA_ASSERT_NOW(a_skid_fill, $rose(skid_valid_q), $past(out_valid_q && pwr_stall),
		"skid filled without a stalled output beat")
	// A finished last antenna shows up on the output in the next cycle.
	`BPA_ASSERT_NEXT(a_result_out, en && rv, out_valid_q, "result lost at output stage")
	// Nothing travels in the pipeline while the store is being cleared.
	`BPA_ASSERT_NOW(a_clear_empty, clr_active_q, !(v_s1 || v_s2 || v_s3 || v_s4 || v_s5),
		"pipeline busy during clearing pass")

endmodule
